FILE: hdl/atrs_pkg.sv
// Types and constants shared by the ant tour roulette step unit.
// Depends on nothing.
package atrs_pkg;

	typedef struct packed {
		logic [1:0]  operation;
		logic [5:0]  row;
		logic [5:0]  col;
		logic [15:0] value;
		logic [5:0]  start_city;
		logic [31:0] random_fraction;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  chosen_city;
		logic        tour_done;
		logic [21:0] tour_length;
		logic [1:0]  status;
	} out_item_t;

	localparam logic [1:0] OP_PHER  = 2'd0;
	localparam logic [1:0] OP_DIST  = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;
	localparam logic [1:0] OP_STEP  = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_RANGE  = 2'd1;
	localparam logic [1:0] ST_NOTOUR = 2'd2;

	localparam logic [1:0] REG_COUNT = 2'd0;
	localparam logic [1:0] REG_ALPHA = 2'd1;
	localparam logic [1:0] REG_BETA  = 2'd2;

	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
	localparam logic [21:0] LEN_MAX = 22'h3F_FFFF;
	localparam int          TW      = 40;

endpackage

FILE: hdl/ant_tour_roulette_step_unit.sv
// Ant tour builder with roulette-wheel city choice, one shared 32x32 multiplier.
// Depends on atrs_pkg.
//
//  channel | direction | payload              | handshake
//  --------+-----------+----------------------+------------------------------
//  in      | input     | atrs_pkg::in_item_t  | in_valid / in_stall
//  out     | output    | atrs_pkg::out_item_t | out_valid / out_stall
//  cfg     | input     | 3 regs at 0,4,8      | APB write in access phase
//
//  Distance write: the inverse distance comes from a 17-step divider.
//  Step: each unvisited city's weight is formed through the shared multiplier,
//  then the target is formed and a prefix walk over the weights picks the city.
//  Reset: a clearing pass over every table entry loads the pheromone table to its
//  initial level; no transaction is taken meanwhile, config writes are.
//  Stalls: one transaction at a time; a finished result waits in the output
//  register while the next transaction is taken, and the sequencer holds its
//  result until that register is free.
module ant_tour_roulette_step_unit #(
	parameter int MAX_CITIES     = 64,
	parameter int PHEROMONE_INIT = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  atrs_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output atrs_pkg::out_item_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import atrs_pkg::*;

	localparam int LIM   = (MAX_CITIES < 64) ? MAX_CITIES : 64;
	localparam int IW    = $clog2(LIM);
	localparam int AW    = 2 * IW;
	localparam int DEPTH = 1 << AW;
	localparam logic [6:0]  LIM7  = 7'(LIM);
	localparam logic [15:0] PINIT = 16'(PHEROMONE_INIT);

	// sequencer states
	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_DIV   = 5'd2;
	localparam logic [4:0] S_RD    = 5'd3;
	localparam logic [4:0] S_LD    = 5'd4;
	localparam logic [4:0] S_MUL   = 5'd5;
	localparam logic [4:0] S_ACC   = 5'd6;
	localparam logic [4:0] S_CHK   = 5'd7;
	localparam logic [4:0] S_T1    = 5'd8;
	localparam logic [4:0] S_T2    = 5'd9;
	localparam logic [4:0] S_T3    = 5'd10;
	localparam logic [4:0] S_WRD   = 5'd11;
	localparam logic [4:0] S_WCMP  = 5'd12;
	localparam logic [4:0] S_FIRST = 5'd13;
	localparam logic [4:0] S_UPD   = 5'd14;
	localparam logic [4:0] S_UPD2  = 5'd15;
	localparam logic [4:0] S_RET   = 5'd16;
	localparam logic [4:0] S_EMIT  = 5'd17;

	logic [4:0]    state_q;
	logic [AW:0]   clr_q;
	in_item_t      item_q;
	out_item_t     res_q;
	out_item_t     out_q;
	logic          out_valid_q;

	logic [6:0]    count_q;
	logic [2:0]    alpha_q, beta_q;

	logic [LIM-1:0] visited_q;
	logic [IW-1:0]  cur_q, first_q, pick_q;
	logic [6:0]     moves_q;
	logic [21:0]    len_q;
	logic           active_q;

	logic [6:0]     i_q;
	logic [2:0]     k_q;
	logic [1:0]     phase_q;
	logic [31:0]    r_q, x_q, pa_q;
	logic [63:0]    prod_q;
	logic [TW-1:0]  total_q, tgt_q, acc_q;
	logic [16:0]    rem_q, quo_q;
	logic [4:0]     cnt_q;

	// memories
	logic [15:0] pher_mem [DEPTH];
	logic [31:0] dist_mem [DEPTH];   // {distance, inverse distance}
	logic [31:0] wbuf_mem [LIM];
	logic [15:0] pd_q;
	logic [31:0] dd_q, wd_q;

	// ---------------- config port ----------------
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_COUNT: prdata = {25'd0, count_q};
			REG_ALPHA: prdata = {29'd0, alpha_q};
			REG_BETA:  prdata = {29'd0, beta_q};
			default:   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 7'd64;
			alpha_q <= 3'd1;
			beta_q  <= 3'd2;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_COUNT: count_q <= pwdata[6:0];
				REG_ALPHA: alpha_q <= pwdata[2:0];
				REG_BETA:  beta_q  <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	// effective count and exponents
	logic [6:0] n;
	logic [2:0] ae, be;
	assign n  = (count_q < 7'd2) ? 7'd2 : ((count_q > LIM7) ? LIM7 : count_q);
	assign ae = (alpha_q > 3'd4) ? 3'd4 : alpha_q;
	assign be = (beta_q > 3'd4) ? 3'd4 : beta_q;

	// ---------------- shared multiplier ----------------
	logic [31:0] mul_a, mul_b;
	always_comb begin
		mul_a = r_q;
		mul_b = x_q;
		if (state_q == S_T1) begin
			mul_a = item_q.random_fraction;
			mul_b = total_q[31:0];
		end else if (state_q == S_T2) begin
			mul_a = item_q.random_fraction;
			mul_b = 32'(total_q[TW-1:32]);
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
	end

	logic [31:0] qres;
	assign qres = (|prod_q[63:48]) ? 32'hFFFF_FFFF : prod_q[47:16];

	// ---------------- divider step ----------------
	logic [16:0] rem_sh, rem_nx;
	logic        qbit;
	logic [16:0] quo_nx;
	logic [15:0] inv_val;
	always_comb begin
		rem_sh  = {rem_q[15:0], (cnt_q == 5'd0)};
		qbit    = rem_sh >= {1'b0, item_q.value};
		rem_nx  = qbit ? (rem_sh - {1'b0, item_q.value}) : rem_sh;
		quo_nx  = {quo_q[15:0], qbit};
		inv_val = (item_q.value < 16'd2) ? 16'hFFFF : quo_nx[15:0];
	end

	// ---------------- memory ports ----------------
	logic            accept;
	logic            in_range_w;
	logic            pw_en, dw_en, wb_en;
	logic [AW-1:0]   pw_addr, dw_addr, rd_addr;
	logic [15:0]     pw_data;
	logic [31:0]     wb_data;
	logic [IW-1:0]   ii, rd_row, rd_col;

	assign accept     = in_valid & ~in_stall;
	assign in_range_w = ({1'b0, in_data.row} < n) && ({1'b0, in_data.col} < n);
	assign ii         = i_q[IW-1:0];

	assign pw_en   = (state_q == S_CLR) ||
	                 (accept && in_data.operation == OP_PHER && in_range_w);
	assign pw_addr = (state_q == S_CLR) ? clr_q[AW-1:0] :
	                 {in_data.row[IW-1:0], in_data.col[IW-1:0]};
	assign pw_data = (state_q == S_CLR) ? PINIT : in_data.value;

	assign dw_en   = (state_q == S_DIV) && (cnt_q == 5'd16);
	assign dw_addr = {item_q.row[IW-1:0], item_q.col[IW-1:0]};

	assign wb_en   = ((state_q == S_LD) && visited_q[ii]) ||
	                 ((state_q == S_CHK) && (phase_q == 2'd2));
	assign wb_data = (state_q == S_LD) ? 32'd0 : r_q;

	assign rd_row  = (state_q == S_UPD2) ? pick_q : cur_q;
	assign rd_col  = (state_q == S_UPD2) ? first_q :
	                 ((state_q == S_UPD) ? pick_q : ii);
	assign rd_addr = {rd_row, rd_col};

	always_ff @(posedge clk) begin
		if (pw_en) pher_mem[pw_addr] <= pw_data;
		pd_q <= pher_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (dw_en) dist_mem[dw_addr] <= {item_q.value, inv_val};
		dd_q <= dist_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wb_en) wbuf_mem[ii] <= wb_data;
		wd_q <= wbuf_mem[ii];
	end

	// ---------------- sequencer ----------------
	logic          last_i;
	logic [TW-1:0] acc_nx;
	logic [22:0]   len_add;
	logic [21:0]   len_sat;
	assign last_i  = (i_q + 7'd1) == n;
	assign acc_nx  = acc_q + TW'(wd_q);
	assign len_add = {1'b0, len_q} + {7'd0, dd_q[31:16]};
	assign len_sat = len_add[22] ? LEN_MAX : len_add[21:0];

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			visited_q <= '0;
			cur_q     <= '0;
			first_q   <= '0;
			moves_q   <= '0;
			len_q     <= '0;
			active_q  <= 1'b0;
			i_q       <= '0;
			k_q       <= '0;
			phase_q   <= '0;
			cnt_q     <= '0;
			total_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_EMIT) out_valid_q <= 1'b0;
			if (cfg_wr && paddr[3:2] == REG_COUNT) active_q <= 1'b0;

			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q[AW-1:0] == AW'(DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						item_q <= in_data;
						case (in_data.operation)
							OP_PHER: begin
								res_q   <= {6'd0, 1'b0, 22'd0,
								            (in_range_w ? ST_OK : ST_RANGE)};
								state_q <= S_EMIT;
							end
							OP_DIST: begin
								res_q <= {6'd0, 1'b0, 22'd0,
								          (in_range_w ? ST_OK : ST_RANGE)};
								if (!in_range_w) begin
									state_q <= S_EMIT;
								end else begin
									rem_q   <= '0;
									quo_q   <= '0;
									cnt_q   <= '0;
									state_q <= S_DIV;
								end
							end
							OP_START: begin
								if ({1'b0, in_data.start_city} >= n) begin
									res_q <= {in_data.start_city, 1'b0, 22'd0, ST_RANGE};
								end else begin
									res_q <= {in_data.start_city, 1'b0, 22'd0, ST_OK};
									visited_q <= LIM'(1) << in_data.start_city[IW-1:0];
									cur_q    <= in_data.start_city[IW-1:0];
									first_q  <= in_data.start_city[IW-1:0];
									moves_q  <= 7'd1;
									len_q    <= '0;
									active_q <= 1'b1;
								end
								state_q <= S_EMIT;
							end
							default: begin
								if (!active_q || moves_q >= n) begin
									res_q    <= {6'd0, 1'b0, 22'd0, ST_NOTOUR};
									active_q <= 1'b0;
									state_q  <= S_EMIT;
								end else begin
									res_q   <= {6'd0, 1'b0, 22'd0, ST_OK};
									i_q     <= '0;
									total_q <= '0;
									state_q <= S_RD;
								end
							end
						endcase
					end
				end
				S_DIV: begin
					rem_q <= rem_nx;
					quo_q <= quo_nx;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd16) state_q <= S_EMIT;
				end
				S_RD: state_q <= S_LD;
				S_LD: begin
					if (visited_q[ii]) begin
						i_q     <= i_q + 7'd1;
						state_q <= last_i ? S_T1 : S_RD;
					end else begin
						r_q     <= ONE_Q16;
						x_q     <= {8'd0, pd_q, 8'd0};
						k_q     <= '0;
						phase_q <= 2'd0;
						state_q <= S_CHK;
					end
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					r_q     <= qres;
					k_q     <= k_q + 3'd1;
					state_q <= S_CHK;
				end
				S_CHK: begin
					case (phase_q)
						2'd0: begin
							if (k_q < ae) begin
								state_q <= S_MUL;
							end else begin
								pa_q    <= r_q;
								r_q     <= ONE_Q16;
								x_q     <= {16'd0, dd_q[15:0]};
								k_q     <= '0;
								phase_q <= 2'd1;
							end
						end
						2'd1: begin
							if (k_q < be) begin
								state_q <= S_MUL;
							end else begin
								x_q     <= pa_q;
								phase_q <= 2'd2;
								state_q <= S_MUL;
							end
						end
						default: begin
							// weight ready in r_q, written to the buffer this cycle
							total_q <= total_q + TW'(r_q);
							i_q     <= i_q + 7'd1;
							state_q <= last_i ? S_T1 : S_RD;
						end
					endcase
				end
				S_T1: begin
					if (total_q == '0) begin
						i_q     <= '0;
						state_q <= S_FIRST;
					end else begin
						state_q <= S_T2;
					end
				end
				S_T2: begin
					tgt_q   <= TW'(prod_q[63:32]);
					state_q <= S_T3;
				end
				S_T3: begin
					tgt_q   <= tgt_q + prod_q[TW-1:0];
					acc_q   <= '0;
					i_q     <= '0;
					state_q <= S_WRD;
				end
				S_WRD: state_q <= S_WCMP;
				S_WCMP: begin
					if (!visited_q[ii] && acc_nx > tgt_q) begin
						pick_q  <= ii;
						state_q <= S_UPD;
					end else begin
						if (!visited_q[ii]) acc_q <= acc_nx;
						if (last_i) begin
							i_q     <= '0;
							state_q <= S_FIRST;
						end else begin
							i_q     <= i_q + 7'd1;
							state_q <= S_WRD;
						end
					end
				end
				S_FIRST: begin
					if (!visited_q[ii]) begin
						pick_q  <= ii;
						state_q <= S_UPD;
					end else if (last_i) begin
						res_q.status <= ST_NOTOUR;
						active_q <= 1'b0;
						state_q  <= S_EMIT;
					end else begin
						i_q <= i_q + 7'd1;
					end
				end
				S_UPD: state_q <= S_UPD2;
				S_UPD2: begin
					len_q <= len_sat;
					visited_q[pick_q] <= 1'b1;
					cur_q   <= pick_q;
					moves_q <= moves_q + 7'd1;
					res_q.chosen_city <= 6'(pick_q);
					state_q <= ((moves_q + 7'd1) >= n) ? S_RET : S_EMIT;
				end
				S_RET: begin
					len_q    <= len_sat;
					res_q    <= {res_q.chosen_city, 1'b1, len_sat, res_q.status};
					active_q <= 1'b0;
					state_q  <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ---------------- assertions ----------------
	a_done_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.tour_done |-> out_data.status == ST_OK)
		else $error("tour_done with bad status");

	a_moves_le_n: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> moves_q <= n)
		else $error("moves beyond city count");

	a_visit_count: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && state_q == S_IDLE |-> $countones(visited_q) == 32'(moves_q))
		else $error("visited mask disagrees with move count");

endmodule
